FILE: rtl/core/block_write_frequency_table_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block write frequency table core
// Shared helpers for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef BLOCK_WRITE_FREQUENCY_TABLE_CORE_MACROS_SVH
`define BLOCK_WRITE_FREQUENCY_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BWFT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bwft assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BWFT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bwft assertion failed");

`endif

FILE: rtl/core/bwft_pkg.sv
// ----------------------------------------------------------------------------
// bwft_pkg
// Types and constants shared by the block write frequency table core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bwft_pkg;

  localparam int unsigned BUCKETS = 1024;
  localparam int unsigned WAYS    = 8;
  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned FILL_W  = $clog2(WAYS + 1);
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Request codes on the slave tuser.
  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_QUERY,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] blk;
  } item_t;

  typedef struct packed {
    logic [WAYS-1:0][CNT_W-1:0] tags;
    logic [WAYS-1:0][CNT_W-1:0] counts;
  } row_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  max;
  } meta_t;

  typedef struct packed {
    logic             dropped;
    logic [CNT_W-1:0] hottest_count;
    logic [CNT_W-1:0] bucket_peak;
    logic [CNT_W-1:0] block_count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/block_write_frequency_table_core.sv
// ----------------------------------------------------------------------------
// block_write_frequency_table_core
// Per-block write counter table with bucket and global peaks.
// ----------------------------------------------------------------------------
// Usage: each slave word is one request; tuser carries the kind (record,
// query, clear) and tdata the block number. Every request yields exactly one
// master word. A record's word carries the block's count, the bucket peak,
// the global peak and a drop flag for a new block that found its bucket full;
// a query's word carries only the global peak, and a clear's word is zero.
// A record reads one bucket row from the table memory, compares the ways and
// writes the row back unless the block is dropped; the back end takes no new
// request until that is done. Queries need no memory access. A clear sweeps
// the bucket state memory one bucket per cycle, then yields its result word.
// After reset the same sweep runs without a result word; requests are queued
// (two deep) but not executed until it completes.
// A stalled master side holds the result word; the core keeps accepting
// requests until the two-entry queue is full, then drops tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_write_frequency_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [31:0] block_number
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [95:0]      m_axis_tdata_o,  // [31:0] block_count, [63:32] bucket_peak,
                                            // [95:64] hottest_count
  output logic             m_axis_tuser_o   // [0] dropped
);

  bwft_pkg::item_t   head;
  logic              head_valid;
  logic              pop;
  bwft_pkg::result_t result;

  // The front end decodes and buffers requests so that the slave side keeps
  // moving while the back end is busy on a row or a clear sweep.
  bwft_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid_i),
    .s_ready_o      (s_axis_tready_o),
    .req_type_i     (s_axis_tuser_i),
    .block_number_i (s_axis_tdata_i),
    .head_o         (head),
    .head_valid_o   (head_valid),
    .pop_i          (pop)
  );

  // The back end owns the table memories and the registered result word.
  bwft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (result),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {result.hottest_count, result.bucket_peak, result.block_count};
  assign m_axis_tuser_o = result.dropped;

endmodule

`default_nettype wire

FILE: rtl/core/bwft_front.sv
// ----------------------------------------------------------------------------
// bwft_front
// Accepts request words, decodes the request kind and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwft_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_valid_i,
  output logic                           s_ready_o,
  input  wire logic [1:0]                req_type_i,
  input  wire logic [bwft_pkg::CNT_W-1:0] block_number_i,
  output bwft_pkg::item_t                head_o,
  output logic                           head_valid_o,
  input  wire logic                      pop_i
);

  bwft_pkg::item_t                queue_q [bwft_pkg::QDEPTH];
  logic [bwft_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [bwft_pkg::QPTR_W:0]      count_q, count_d;
  bwft_pkg::item_t                in_item;
  logic                           push, pop;

  // Unused code 3 is handled as a query.
  always_comb begin
    in_item.blk = block_number_i;
    unique case (req_type_i)
      bwft_pkg::REQ_RECORD: in_item.op = bwft_pkg::OP_RECORD;
      bwft_pkg::REQ_CLEAR:  in_item.op = bwft_pkg::OP_CLEAR;
      default:              in_item.op = bwft_pkg::OP_QUERY;
    endcase
  end

  assign s_ready_o    = (count_q != (bwft_pkg::QPTR_W+1)'(bwft_pkg::QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];
  assign push         = s_valid_i && s_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == bwft_pkg::QPTR_W'(bwft_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == bwft_pkg::QPTR_W'(bwft_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bwft_back.sv
// ----------------------------------------------------------------------------
// bwft_back
// Executes queued requests against the bucket memories and drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwft_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  bwft_pkg::item_t      head_i,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  output bwft_pkg::result_t    out_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [bwft_pkg::BKT_W-1:0]      clr_idx_q, clr_idx_d;
  logic                            report_q, report_d;
  logic [bwft_pkg::CNT_W-1:0]      global_q, global_d;
  bwft_pkg::item_t                 item_q, item_d;
  bwft_pkg::result_t               out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  bwft_pkg::row_t                  row_mem [bwft_pkg::BUCKETS];
  bwft_pkg::meta_t                 meta_mem [bwft_pkg::BUCKETS];
  bwft_pkg::row_t                  row_rd_q;
  bwft_pkg::meta_t                 meta_rd_q;

  logic                            rd_en;
  logic [bwft_pkg::BKT_W-1:0]      rd_addr;
  logic                            row_we, meta_we;
  logic [bwft_pkg::BKT_W-1:0]      wr_addr;
  bwft_pkg::row_t                  row_wdata;
  bwft_pkg::meta_t                 meta_wdata;
  logic                            out_free;

  // Lookup results for the bucket row held in row_rd_q.
  logic [bwft_pkg::FILL_W-1:0]     fill;
  logic                            hit, drop;
  logic [bwft_pkg::CNT_W-1:0]      hit_cnt, cnt, new_max;
  bwft_pkg::row_t                  row_new;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    fill = (meta_rd_q.fill > bwft_pkg::FILL_W'(bwft_pkg::WAYS))
           ? bwft_pkg::FILL_W'(bwft_pkg::WAYS) : meta_rd_q.fill;
    hit     = 1'b0;
    hit_cnt = '0;
    row_new = row_rd_q;
    for (int w = 0; w < bwft_pkg::WAYS; w++) begin
      if (!hit && (bwft_pkg::FILL_W'(w) < fill) && (row_rd_q.tags[w] == item_q.blk)) begin
        hit     = 1'b1;
        hit_cnt = (row_rd_q.counts[w] == bwft_pkg::COUNT_MAX)
                  ? row_rd_q.counts[w] : row_rd_q.counts[w] + 1'b1;
        row_new.counts[w] = hit_cnt;
      end
    end
    drop = !hit && (fill == bwft_pkg::FILL_W'(bwft_pkg::WAYS));
    if (!hit) begin
      for (int w = 0; w < bwft_pkg::WAYS; w++) begin
        if (bwft_pkg::FILL_W'(w) == fill) begin
          row_new.tags[w]   = item_q.blk;
          row_new.counts[w] = bwft_pkg::CNT_W'(1);
        end
      end
    end
    cnt     = hit ? hit_cnt : (drop ? '0 : bwft_pkg::CNT_W'(1));
    new_max = (cnt > meta_rd_q.max) ? cnt : meta_rd_q.max;
  end

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    report_d    = report_q;
    global_d    = global_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_i.blk[bwft_pkg::BKT_W-1:0];
    row_we      = 1'b0;
    meta_we     = 1'b0;
    wr_addr     = item_q.blk[bwft_pkg::BKT_W-1:0];
    row_wdata   = row_new;
    meta_wdata.fill = fill + 1'b1;
    meta_wdata.max  = new_max;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i && out_free) begin
          pop_o = 1'b1;
          unique case (head_i.op)
            bwft_pkg::OP_RECORD: begin
              rd_en   = 1'b1;
              item_d  = head_i;
              state_d = ST_EXEC;
            end
            bwft_pkg::OP_CLEAR: begin
              clr_idx_d = '0;
              report_d  = 1'b1;
              state_d   = ST_CLEAR;
            end
            default: begin
              out_d       = '{dropped: 1'b0, hottest_count: global_q,
                              bucket_peak: '0, block_count: '0};
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (!drop) begin
          row_we  = 1'b1;
          meta_we = 1'b1;
          if (hit) begin
            meta_wdata.fill = meta_rd_q.fill;
          end
          if (cnt > global_q) begin
            global_d = cnt;
          end
        end
        out_d.dropped       = drop;
        out_d.block_count   = cnt;
        out_d.bucket_peak   = drop ? '0 : new_max;
        out_d.hottest_count = (!drop && cnt > global_q) ? cnt : global_q;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_CLEAR: begin
        meta_we    = 1'b1;
        wr_addr    = clr_idx_q;
        meta_wdata = '0;
        clr_idx_d  = clr_idx_q + 1'b1;
        if (clr_idx_q == bwft_pkg::BKT_W'(bwft_pkg::BUCKETS - 1)) begin
          global_d = '0;
          report_d = 1'b0;
          state_d  = ST_IDLE;
          if (report_q) begin
            out_d       = '0;
            out_valid_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      report_q    <= 1'b0;
      global_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      report_q    <= report_d;
      global_q    <= global_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      row_rd_q  <= row_mem[rd_addr];
      meta_rd_q <= meta_mem[rd_addr];
    end
    if (row_we) begin
      row_mem[wr_addr] <= row_wdata;
    end
    if (meta_we) begin
      meta_mem[wr_addr] <= meta_wdata;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/bwft_checker.sv
// ----------------------------------------------------------------------------
// bwft_checker
// Port-level checks on the result stream of the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_write_frequency_table_core_macros.svh"

module bwft_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [95:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  `BWFT_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `BWFT_ASSERT_IMP(a_drop_zero, m_axis_tvalid_o && m_axis_tuser_o,
                   m_axis_tdata_o[63:0] == 64'd0)
  `BWFT_ASSERT_IMP(a_peaks_order,
                   m_axis_tvalid_o && !m_axis_tuser_o && m_axis_tdata_o[31:0] != 32'd0,
                   (m_axis_tdata_o[63:32] >= m_axis_tdata_o[31:0]) &&
                   (m_axis_tdata_o[95:64] >= m_axis_tdata_o[63:32]))
  `BWFT_ASSERT_IMP(a_no_count_no_peak, m_axis_tvalid_o && m_axis_tdata_o[31:0] == 32'd0,
                   m_axis_tdata_o[63:32] == 32'd0)

endmodule

bind block_write_frequency_table_core bwft_checker u_bwft_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block write frequency table core.
// ----------------------------------------------------------------------------
// A queue of requests is filled up front and fed to the slave side by a
// clocked driver. Each accepted word updates a local copy of the count
// table, which yields the result word that is expected. A clocked monitor
// compares every master word against the oldest expected result.
// The run has three phases with different amounts of idling on the two sides.
// Between phases the sender waits until every expected result has come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // Code 3 is not used by the core and must behave as a query.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 650;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [bwft_pkg::CNT_W-1:0] blk;
  } request_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [31:0]       s_axis_tdata_i = '0;
  logic [1:0]        s_axis_tuser_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [95:0]       m_axis_tdata_o;
  logic              m_axis_tuser_o;

  block_write_frequency_table_core DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the table state.
  logic [bwft_pkg::CNT_W-1:0] way_tag   [bwft_pkg::BUCKETS*bwft_pkg::WAYS];
  logic [bwft_pkg::CNT_W-1:0] way_count [bwft_pkg::BUCKETS*bwft_pkg::WAYS];
  int unsigned                fill_of   [bwft_pkg::BUCKETS];
  logic [bwft_pkg::CNT_W-1:0] peak_of   [bwft_pkg::BUCKETS];
  logic [bwft_pkg::CNT_W-1:0] hottest;

  request_t          pending_reqs[$];
  bwft_pkg::result_t expected_results[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  bit                hold_sender = 1'b0;
  int unsigned       mismatches = 0;
  int unsigned       n_records = 0, n_drops = 0, n_clears = 0, n_other = 0;
  int unsigned       n_results = 0;

  // Applies one request to the local table and returns the word it causes.
  function automatic bwft_pkg::result_t update_table(request_t r);
    bwft_pkg::result_t res;
    int unsigned       b, base, fill;
    bit                hit;
    res = '0;
    hit = 1'b0;
    if (r.kind == bwft_pkg::REQ_RECORD) begin
      b    = r.blk % bwft_pkg::BUCKETS;
      base = b * bwft_pkg::WAYS;
      fill = fill_of[b];
      for (int w = 0; w < bwft_pkg::WAYS; w++) begin
        if (!hit && w < fill && way_tag[base+w] == r.blk) begin
          if (way_count[base+w] != bwft_pkg::COUNT_MAX) way_count[base+w]++;
          res.block_count = way_count[base+w];
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (fill < bwft_pkg::WAYS) begin
          way_tag[base+fill]   = r.blk;
          way_count[base+fill] = bwft_pkg::CNT_W'(1);
          fill_of[b]           = fill + 1;
          res.block_count      = bwft_pkg::CNT_W'(1);
        end else begin
          res.dropped = 1'b1;
        end
      end
      if (!res.dropped) begin
        if (res.block_count > peak_of[b]) peak_of[b] = res.block_count;
        if (res.block_count > hottest) hottest = res.block_count;
        res.bucket_peak = peak_of[b];
      end
    end else if (r.kind == bwft_pkg::REQ_CLEAR) begin
      for (int i = 0; i < bwft_pkg::BUCKETS; i++) begin
        fill_of[i] = 0;
        peak_of[i] = '0;
      end
      hottest = '0;
    end
    res.hottest_count = hottest;
    return res;
  endfunction

  // Driver: holds a word until it is taken, then loads the next one unless
  // the sender idles this cycle.
  always @(posedge clk_i) begin
    logic     load;
    request_t nxt;
    if (rst_ni) begin
      load = !s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_results.push_back(update_table({s_axis_tuser_i, s_axis_tdata_i}));
        load = 1'b1;
      end
      if (load) begin
        if (pending_reqs.size() > 0 && !hold_sender &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          case (nxt.kind)
            bwft_pkg::REQ_RECORD: n_records++;
            bwft_pkg::REQ_CLEAR:  n_clears++;
            default:              n_other++;
          endcase
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= nxt.kind;
          s_axis_tdata_i  <= nxt.blk;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and a field-by-field check of each word.
  always @(posedge clk_i) begin
    bwft_pkg::result_t exp_res;
    bwft_pkg::result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tuser_o, m_axis_tdata_o};
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.dropped) n_drops++;
          if (got.block_count !== exp_res.block_count ||
              got.bucket_peak !== exp_res.bucket_peak ||
              got.hottest_count !== exp_res.hottest_count ||
              got.dropped !== exp_res.dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: count %h/%h peak %h/%h hottest %h/%h drop %b/%b (exp/got)",
                       exp_res.block_count, got.block_count, exp_res.bucket_peak,
                       got.bucket_peak, exp_res.hottest_count, got.hottest_count,
                       exp_res.dropped, got.dropped);
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    r.blk = $urandom;
    if (pick < 86) begin
      r.kind = bwft_pkg::REQ_RECORD;
      // Mostly a few hot buckets and a few tags, so buckets fill and overflow.
      if ($urandom_range(99, 0) < 75)
        r.blk[bwft_pkg::BKT_W-1:0] = bwft_pkg::BKT_W'($urandom_range(5, 0));
      if ($urandom_range(99, 0) < 75)
        r.blk[31:bwft_pkg::BKT_W] = (32 - bwft_pkg::BKT_W)'($urandom_range(10, 0));
    end else if (pick < 94) begin
      r.kind = bwft_pkg::REQ_QUERY;
    end else if (pick < 99) begin
      r.kind = REQ_UNUSED;
    end else begin
      r.kind = bwft_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  // Lets the queue run empty, then keeps the sender quiet until every
  // expected word has come back.
  task automatic drain();
    while (pending_reqs.size() > 0)
      @(posedge clk_i);
    hold_sender = 1'b1;
    while (s_axis_tvalid_i || expected_results.size() > 0)
      @(posedge clk_i);
    hold_sender = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < bwft_pkg::BUCKETS; i++) begin
      fill_of[i] = 0;
      peak_of[i] = '0;
    end
    hottest = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty table, both block extremes, an overflowing bucket,
    // hits after overflow, the unused code and a clear.
    pending_reqs.push_back({bwft_pkg::REQ_QUERY, 32'h0});
    pending_reqs.push_back({bwft_pkg::REQ_RECORD, 32'h0});
    pending_reqs.push_back({bwft_pkg::REQ_RECORD, 32'hFFFF_FFFF});
    pending_reqs.push_back({bwft_pkg::REQ_RECORD, 32'h0});
    for (int w = 0; w <= bwft_pkg::WAYS; w++)
      pending_reqs.push_back({bwft_pkg::REQ_RECORD, (32'(w) << bwft_pkg::BKT_W) | 32'd5});
    pending_reqs.push_back({bwft_pkg::REQ_RECORD, (32'd3 << bwft_pkg::BKT_W) | 32'd5});
    pending_reqs.push_back({bwft_pkg::REQ_RECORD, (32'd9 << bwft_pkg::BKT_W) | 32'd5});
    pending_reqs.push_back({REQ_UNUSED, 32'hFFFF_FFFF});
    pending_reqs.push_back({bwft_pkg::REQ_CLEAR, 32'h0});
    pending_reqs.push_back({bwft_pkg::REQ_QUERY, 32'hAAAA_5555});
    pending_reqs.push_back({bwft_pkg::REQ_RECORD, (32'd9 << bwft_pkg::BKT_W) | 32'd5});
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 12 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_reqs.push_back(random_request());
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Covered %0d records (%0d dropped), %0d clears, %0d queries; %0d words checked.",
             n_records, n_drops, n_clears, n_other, n_results);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bwft_pkg.sv
rtl/core/bwft_front.sv
rtl/core/bwft_back.sv
rtl/core/block_write_frequency_table_core.sv
rtl/core/bwft_checker.sv
tb/sv/tb_top.sv
